/* hdl/cdil_pkg.sv */
package cdil_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int REACH      = 2;
  localparam int WIN_ROWS   = 2 * REACH + 1;

  localparam int COL_W   = 8;
  localparam int ROW_W   = 8;
  localparam int DIM_W   = 9;
  localparam int SLOT_W  = $clog2(WIN_ROWS);
  localparam int PROBE_W = $clog2(WIN_ROWS);
  localparam int AMT_W   = 16;

  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_TILES_PER_ROW = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_ROWS_PER_MAP  = REG_IDX_W'(1);

  localparam logic [DIM_W-1:0] MAX_WIDTH_C  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_HEIGHT_C = DIM_W'(MAX_HEIGHT);
  localparam logic [AMT_W-1:0] GRANITE_FULL = AMT_W'(65000);

  typedef struct packed {
    logic              we;
    logic [COL_W-1:0]  waddr;
    logic [SLOT_W-1:0] wslot;
    logic              wbit;
    logic              re;
    logic [COL_W-1:0]  raddr;
  } store_req_t;

  // zero acts as one, oversize clamps to the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > maxv) begin
      return maxv;
    end
    return v;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(WIN_ROWS - 1)) ? '0 : s + 1'b1;
  endfunction

  // s - d modulo the window height, d below the window height
  function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] d);
    logic [SLOT_W:0] t;
    t = {1'b0, s} + (SLOT_W+1)'(WIN_ROWS) - {1'b0, d};
    if (s >= d) begin
      return s - d;
    end
    return t[SLOT_W-1:0];
  endfunction

endpackage

/* hdl/cdil_cfg_regs.sv */
module cdil_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cdil_pkg::APB_AW-1:0]    paddr,
  input  logic [cdil_pkg::APB_DW-1:0]    pwdata,
  output logic [cdil_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  output logic [cdil_pkg::DIM_W-1:0]     tiles_per_row_o,
  output logic [cdil_pkg::DIM_W-1:0]     rows_per_map_o
);
  import cdil_pkg::*;

  logic [DIM_W-1:0]     tiles_per_row_q, rows_per_map_q;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiles_per_row_q <= MAX_WIDTH_C;
      rows_per_map_q  <= MAX_HEIGHT_C;
    end else if (wr_en) begin
      unique case (idx)
        REG_TILES_PER_ROW: tiles_per_row_q <= pwdata[DIM_W-1:0];
        REG_ROWS_PER_MAP:  rows_per_map_q  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_TILES_PER_ROW: prdata = APB_DW'(tiles_per_row_q);
      REG_ROWS_PER_MAP:  prdata = APB_DW'(rows_per_map_q);
      default:           prdata = '0;
    endcase
  end

  assign tiles_per_row_o = tiles_per_row_q;
  assign rows_per_map_o  = rows_per_map_q;

endmodule

/* hdl/cdil_line_store.sv */
module cdil_line_store (
  input  logic                           clk_i,
  input  cdil_pkg::store_req_t           req_i,
  output logic [cdil_pkg::WIN_ROWS-1:0]  rdata_o
);
  import cdil_pkg::*;

  // one word per column, one bit per row slot of the window
  logic [WIN_ROWS-1:0] mem_q [MAX_WIDTH];
  logic [WIN_ROWS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr][req_i.wslot] <= req_i.wbit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/chebyshev_dilation_stream_top.sv */
// A tile that completes no neighborhood is absorbed without a sweep, and ready stays high.
// Otherwise each result is produced by a sweep (5 column reads of the line store, one read
// drain), and the next sweep starts once the previous result is taken; up to 9 results
// per input.
// Ready returns only after the last result of the run is taken.
// Reset: counters clear, dimension registers return to 256, line store not cleared.
module chebyshev_dilation_stream_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          is_rock_i,
  // result stream
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cdil_pkg::COL_W-1:0]    tile_x_o,
  output logic [cdil_pkg::ROW_W-1:0]    tile_y_o,
  output logic [cdil_pkg::AMT_W-1:0]    granite_amount_o,
  output logic                          last_of_run_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cdil_pkg::APB_AW-1:0]   paddr,
  input  logic [cdil_pkg::APB_DW-1:0]   pwdata,
  output logic [cdil_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import cdil_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_OUT
  } state_e;

  state_e state_q;

  // ---------------------------------------------------------------------------
  // Configuration registers and effective dimensions
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] tiles_per_row, rows_per_map;
  logic [DIM_W-1:0] w_eff, h_eff;

  cdil_cfg_regs u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .tiles_per_row_o (tiles_per_row),
    .rows_per_map_o  (rows_per_map)
  );

  assign w_eff = eff_dim(tiles_per_row, MAX_WIDTH_C);
  assign h_eff = eff_dim(rows_per_map, MAX_HEIGHT_C);

  // ---------------------------------------------------------------------------
  // Input position: the counters hold the next tile in raster order, the slot
  // tracks row mod window height so the line store needs no division.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic              accept;
  logic              col_wrap, row_wrap;
  logic [DIM_W-1:0]  row_a;
  logic [SLOT_W-1:0] slot_a;
  logic [COL_W-1:0]  cx;
  logic [ROW_W-1:0]  cy;
  logic [SLOT_W-1:0] cs;
  logic [DIM_W-1:0]  col_n, row_n;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    // fold a stale position back into the map first (dimensions may shrink)
    col_wrap = {1'b0, col_q} >= w_eff;
    row_a    = col_wrap ? {1'b0, row_q} + 1'b1 : {1'b0, row_q};
    slot_a   = col_wrap ? slot_inc(slot_q) : slot_q;
    row_wrap = row_a >= h_eff;
    cx       = col_wrap ? '0 : col_q;
    cy       = row_wrap ? '0 : row_a[ROW_W-1:0];
    cs       = row_wrap ? '0 : slot_a;

    // advance past the tile just taken
    col_n  = {1'b0, cx} + 1'b1;
    row_n  = {1'b0, cy} + 1'b1;
    col_d  = col_n[COL_W-1:0];
    row_d  = cy;
    slot_d = cs;
    if (col_n >= w_eff) begin
      col_d = '0;
      if (row_n >= h_eff) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = row_n[ROW_W-1:0];
        slot_d = slot_inc(cs);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tiles completed by this input: a column/row range on each axis
  // ---------------------------------------------------------------------------
  logic              x_last, x_far, x_any;
  logic              y_last, y_far, y_any;
  logic [COL_W-1:0]  xlo, xhi;
  logic [ROW_W-1:0]  ylo, yhi;
  logic [ROW_W-1:0]  y_dist;
  logic [SLOT_W-1:0] ts_first;

  always_comb begin
    x_last = {1'b0, cx} == (w_eff - 1'b1);
    x_far  = cx >= COL_W'(REACH);
    x_any  = x_last || x_far;
    xhi    = x_last ? cx : cx - COL_W'(REACH);
    xlo    = x_far ? cx - COL_W'(REACH) : '0;

    y_last = {1'b0, cy} == (h_eff - 1'b1);
    y_far  = cy >= ROW_W'(REACH);
    y_any  = y_last || y_far;
    yhi    = y_last ? cy : cy - ROW_W'(REACH);
    ylo    = y_far ? cy - ROW_W'(REACH) : '0;

    y_dist   = cy - ylo;
    ts_first = slot_sub(cs, y_dist[SLOT_W-1:0]);
  end

  // ---------------------------------------------------------------------------
  // Sweep registers
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]   tx_q, xlo_q, xhi_q;
  logic [ROW_W-1:0]   ty_q, yhi_q;
  logic [SLOT_W-1:0]  ts_q;
  logic [PROBE_W-1:0] k_q;
  logic               hit_q;
  logic               rd_ok_q;

  logic [COL_W-1:0]   tile_x_q;
  logic [ROW_W-1:0]   tile_y_q;
  logic [AMT_W-1:0]   amount_q;
  logic               last_q;

  // ---------------------------------------------------------------------------
  // Column probe: one neighbor column of the current tile per cycle
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] probe, probe_col;
  logic             probe_ok;

  assign probe     = {1'b0, tx_q} + DIM_W'(k_q);
  assign probe_col = probe - DIM_W'(REACH);
  assign probe_ok  = (probe >= DIM_W'(REACH)) && (probe_col < w_eff);

  // Row mask: window slots whose rows lie inside the map for the current tile
  logic [WIN_ROWS-1:0] row_mask;
  logic [SLOT_W-1:0]   mask_slot;
  logic [DIM_W-1:0]    mask_row;

  always_comb begin
    row_mask  = '0;
    mask_slot = slot_sub(ts_q, SLOT_W'(REACH));
    mask_row  = '0;
    for (int d = 0; d < WIN_ROWS; d++) begin
      mask_row = {1'b0, ty_q} + DIM_W'(d);
      if ((mask_row >= DIM_W'(REACH)) && ((mask_row - DIM_W'(REACH)) < h_eff)) begin
        row_mask[mask_slot] = 1'b1;
      end
      mask_slot = slot_inc(mask_slot);
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: write the new flag on the input transaction, read while sweeping
  // ---------------------------------------------------------------------------
  store_req_t          store_req;
  logic [WIN_ROWS-1:0] store_rdata;
  logic                hit_now;

  always_comb begin
    store_req.we    = accept;
    store_req.waddr = cx;
    store_req.wslot = cs;
    store_req.wbit  = is_rock_i;
    store_req.re    = (state_q == ST_READ);
    store_req.raddr = probe_col[COL_W-1:0];
  end

  cdil_line_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  // read data is registered: it arrives in the cycle after its address
  assign hit_now = rd_ok_q && (|(store_rdata & row_mask));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      col_q    <= '0;
      row_q    <= '0;
      slot_q   <= '0;
      tx_q     <= '0;
      ty_q     <= '0;
      ts_q     <= '0;
      xlo_q    <= '0;
      xhi_q    <= '0;
      yhi_q    <= '0;
      k_q      <= '0;
      hit_q    <= 1'b0;
      rd_ok_q  <= 1'b0;
      tile_x_q <= '0;
      tile_y_q <= '0;
      amount_q <= '0;
      last_q   <= 1'b0;
    end else begin
      // mark which read returns data on the next cycle
      rd_ok_q <= (state_q == ST_READ) && probe_ok;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            // advance the position at once: the sweep keeps its own copies
            col_q  <= col_d;
            row_q  <= row_d;
            slot_q <= slot_d;
            if (x_any && y_any) begin
              tx_q    <= xlo;
              ty_q    <= ylo;
              ts_q    <= ts_first;
              xlo_q   <= xlo;
              xhi_q   <= xhi;
              yhi_q   <= yhi;
              k_q     <= '0;
              hit_q   <= 1'b0;
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          hit_q   <= hit_q | hit_now;
          k_q     <= k_q + 1'b1;
          if (k_q == PROBE_W'(WIN_ROWS - 1)) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // drain the last column read and load the output register
          tile_x_q <= tx_q;
          tile_y_q <= ty_q;
          amount_q <= (hit_q || hit_now) ? GRANITE_FULL : '0;
          last_q   <= (tx_q == xhi_q) && (ty_q == yhi_q);
          state_q  <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            if (last_q) begin
              state_q <= ST_IDLE;
            end else begin
              if (tx_q == xhi_q) begin
                tx_q <= xlo_q;
                ty_q <= ty_q + 1'b1;
                ts_q <= slot_inc(ts_q);
              end else begin
                tx_q <= tx_q + 1'b1;
              end
              k_q     <= '0;
              hit_q   <= 1'b0;
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = (state_q == ST_OUT);
  assign tile_x_o         = tile_x_q;
  assign tile_y_o         = tile_y_q;
  assign granite_amount_o = amount_q;
  assign last_of_run_o    = last_q;

`ifndef SYNTHESIS
  // never take a new input while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result is pending");

  // reported tile lies inside the map
  a_tile_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (({1'b0, tile_x_o} < w_eff) && ({1'b0, tile_y_o} < h_eff)))
    else $error("reported tile outside the map");

  // amount is all or nothing
  a_amount_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((granite_amount_o == '0) || (granite_amount_o == GRANITE_FULL)))
    else $error("granite amount neither zero nor full");

  // taking the last result of a run frees the input side
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_of_run_o) |=> in_ready_o)
    else $error("input not ready after the last result");

  // a result that is not last is followed by another sweep, not by idle
  a_not_last_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_run_o) |=> (!in_ready_o && !out_valid_o))
    else $error("run ended before its last result");
`endif

endmodule
